[hw/rtl/iirdf1_pkg.sv]
// types and constants for the fourth-order direct form I filter
// no dependencies; imported by iirdf1_core and the top level
`timescale 1ns / 1ps
`default_nettype none
package iirdf1_pkg;

  localparam int TAPS      = 5;
  localparam int HIST      = TAPS - 1;
  localparam int SMP_W     = 16;
  localparam int COEF_W    = 24;
  localparam int PROD_W    = SMP_W + COEF_W;
  localparam int ACC_W     = PROD_W + 5;
  localparam int FRAC_BITS = 20;
  localparam int CFG_W     = 2 * COEF_W;
  localparam int REG_IDX_W = 3;

  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    coef_t [TAPS-1:0] b;
    coef_t [HIST-1:0] a;
  } coef_set_t;

  localparam logic [REG_IDX_W-1:0] REG_B_NOW     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_B_LAG4    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_A_LAG1_2  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_A_LAG3_4  = 3'd6;

  localparam coef_t COEF_ONE = coef_t'(1 << FRAC_BITS);
  localparam smp_t  SMP_MAX  = smp_t'(16'h7fff);
  localparam smp_t  SMP_MIN  = smp_t'(16'h8000);

endpackage
`default_nettype wire

[hw/rtl/iirdf1_core.sv]
// multiply-accumulate, rounding and saturation for one output sample
// depends on iirdf1_pkg
`timescale 1ns / 1ps
`default_nettype none
module iirdf1_core (
  input  wire iirdf1_pkg::smp_t                   x,
  input  wire iirdf1_pkg::smp_t [iirdf1_pkg::HIST-1:0] x_hist,
  input  wire iirdf1_pkg::smp_t [iirdf1_pkg::HIST-1:0] y_hist,
  input  wire iirdf1_pkg::coef_set_t              coefs,
  output iirdf1_pkg::smp_t                        y,
  output logic                                    clip
);
  import iirdf1_pkg::*;

  prod_t             p_now;
  prod_t [HIST-1:0]  p_ff;
  prod_t [HIST-1:0]  p_fb;
  acc_t              acc;
  acc_t              rnd;
  acc_t              yw;
  logic [ACC_W-1:SMP_W-1] hi;

  always_comb begin
    p_now = coefs.b[0] * x;
    for (int k = 0; k < HIST; k++) begin
      p_ff[k] = coefs.b[k+1] * x_hist[k];
      p_fb[k] = coefs.a[k] * y_hist[k];
    end
  end

  // adder tree: feed-forward minus feedback
  assign acc = acc_t'(p_now)
             + ((acc_t'(p_ff[0]) + acc_t'(p_ff[1])) + (acc_t'(p_ff[2]) + acc_t'(p_ff[3])))
             - ((acc_t'(p_fb[0]) + acc_t'(p_fb[1])) + (acc_t'(p_fb[2]) + acc_t'(p_fb[3])));

  // round half up, then floor shift
  assign rnd = acc + acc_t'(1 << (FRAC_BITS - 1));
  assign yw  = rnd >>> FRAC_BITS;
  assign hi  = yw[ACC_W-1:SMP_W-1];

  always_comb begin
    clip = !((&hi) || (~|hi));
    if (clip) begin
      y = yw[ACC_W-1] ? SMP_MIN : SMP_MAX;
    end else begin
      y = yw[SMP_W-1:0];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/iir_direct_form_one_order4_top.sv]
// an accepted input is held in the input register; its result is registered once the output is not stalled
// throughput: one sample per cycle while the output is not stalled; the feedback loop is the
//   combinational multiply-accumulate from the input register into the output history
// reset (rst_n low, synchronous): histories cleared, b_now = 1.0, other coefficients 0
// depends on iirdf1_pkg and iirdf1_core
`timescale 1ns / 1ps
`default_nettype none
module iir_direct_form_one_order4_top (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire iirdf1_pkg::smp_t                 in_sample_in,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output iirdf1_pkg::smp_t                      out_sample_out,
  output logic                                  out_clipped,
  input  wire                                   cfg_we,
  input  wire [iirdf1_pkg::REG_IDX_W-1:0]       cfg_index,
  input  wire [iirdf1_pkg::CFG_W-1:0]           cfg_data
);
  import iirdf1_pkg::*;

  coef_t [TAPS-1:0] b_r;
  logic [CFG_W-1:0] a12_r;
  logic [CFG_W-1:0] a34_r;
  coef_set_t        coefs;

  logic             s1_vld_r;
  smp_t             s1_sample_r;
  logic             out_vld_r;
  smp_t             out_sample_r;
  logic             out_clip_r;
  smp_t [HIST-1:0]  xh_r;
  smp_t [HIST-1:0]  yh_r;
  smp_t [HIST-1:0]  xh_nxt;
  smp_t [HIST-1:0]  yh_nxt;

  smp_t             y_calc;
  logic             clip_calc;
  logic             advance;
  logic             in_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r    <= {{((TAPS-1)*COEF_W){1'b0}}, COEF_ONE};
      a12_r  <= '0;
      a34_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index) inside
        [REG_B_NOW:REG_B_LAG4]: begin
          b_r[cfg_index] <= cfg_data[COEF_W-1:0];
        end
        REG_A_LAG1_2: begin
          a12_r <= cfg_data;
        end
        REG_A_LAG3_4: begin
          a34_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  assign coefs.b    = b_r;
  assign coefs.a[0] = a12_r[COEF_W-1:0];
  assign coefs.a[1] = a12_r[CFG_W-1:COEF_W];
  assign coefs.a[2] = a34_r[COEF_W-1:0];
  assign coefs.a[3] = a34_r[CFG_W-1:COEF_W];

  // handshake
  assign advance   = !out_vld_r || !out_stall;
  assign in_stall  = s1_vld_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_vld_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clip_r;

  iirdf1_core u_core (
    .x      (s1_sample_r),
    .x_hist (xh_r),
    .y_hist (yh_r),
    .coefs  (coefs),
    .y      (y_calc),
    .clip   (clip_calc)
  );

  assign xh_nxt = {xh_r[HIST-2:0], s1_sample_r};
  assign yh_nxt = {yh_r[HIST-2:0], y_calc};

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_take) begin
      s1_vld_r <= 1'b1;
    end else if (advance) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= in_sample_in;
    end
  end

  // result register and histories
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      xh_r      <= '0;
      yh_r      <= '0;
    end else if (advance) begin
      out_vld_r <= s1_vld_r;
      if (s1_vld_r) begin
        xh_r <= xh_nxt;
        yh_r <= yh_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_vld_r) begin
      out_sample_r <= y_calc;
      out_clip_r   <= clip_calc;
    end
  end

  // checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with empty input register");

  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |=> ($stable(yh_r) && $stable(xh_r)))
    else $error("history changed while result stalled");

  a_hist_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (yh_r[0] == out_sample_r))
    else $error("output history out of step with result");

  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_clip_r) |-> (out_sample_r == SMP_MAX || out_sample_r == SMP_MIN))
    else $error("clipped result not at a rail");

endmodule
`default_nettype wire
